// File: hdl/ldi_pkg.sv
package ldi_pkg;

  localparam int unsigned ITERATIONS = 10;
  localparam int unsigned DIV_STEPS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = 32 / DIV_STEPS_PER_STAGE;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIAL_K1     = 3'd0,
    REG_RADIAL_K2     = 3'd1,
    REG_RADIAL_K3     = 3'd2,
    REG_TANGENTIAL_P1 = 3'd3,
    REG_TANGENTIAL_P2 = 3'd4
  } ldi_reg_e;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } ldi_coef_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               fault;
  } ldi_item_t;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

endpackage

// File: hdl/ldi_iter.sv
module ldi_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ldi_pkg::ldi_coef_t coef_i,
  input  logic               valid_i,
  input  ldi_pkg::ldi_item_t item_i,
  output logic               valid_o,
  output ldi_pkg::ldi_item_t item_o
);

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] low;
    logic [31:0] q;
    logic        ovf;
    logic        rneg;
    logic        nneg;
    logic        nzero;
  } ldi_lane_t;

  typedef struct packed {
    ldi_pkg::ldi_item_t item;
    logic [31:0]        gabs;
    logic               gz;
    ldi_lane_t          lx;
    ldi_lane_t          ly;
  } ldi_dv_t;

  logic [9:1] v_q;

  // stage 1: squares and cross product
  ldi_pkg::ldi_item_t it1_q;
  logic signed [63:0] pxx_q, pyy_q, pxy_q;
  // stage 2
  ldi_pkg::ldi_item_t it2_q;
  logic signed [31:0] x2_q, y2_q, xy_q;
  // stage 3
  ldi_pkg::ldi_item_t it3_q;
  logic signed [31:0] x2b_q, y2b_q, r2_q, xy2_q;
  // stage 4
  ldi_pkg::ldi_item_t it4_q;
  logic signed [31:0] r2b_q, xy2b_q, sx_q, sy_q;
  logic signed [63:0] m4_q;
  // stage 5
  ldi_pkg::ldi_item_t it5_q;
  logic signed [31:0] r2c_q, acc1_q;
  logic signed [63:0] tp0_q, tp1_q, tp2_q, tp3_q;
  // stage 6
  ldi_pkg::ldi_item_t it6_q;
  logic signed [31:0] r2d_q;
  logic signed [63:0] m6_q;
  logic signed [40:0] tx_q, ty_q;
  // stage 7
  ldi_pkg::ldi_item_t it7_q;
  logic signed [31:0] r2e_q, acc2_q, nx_q, ny_q;
  // stage 8
  ldi_pkg::ldi_item_t it8_q;
  logic signed [31:0] nx8_q, ny8_q;
  logic signed [63:0] m8_q;
  // stage 9
  ldi_pkg::ldi_item_t it9_q;
  logic signed [31:0] nx9_q, ny9_q, g_q;

  logic f2, f3, f4, f5, f7, f9;

  assign f2 = ldi_pkg::ovf32(66'(pxx_q >>> 28)) | ldi_pkg::ovf32(66'(pyy_q >>> 28))
            | ldi_pkg::ovf32(66'(pxy_q >>> 28));
  assign f3 = ldi_pkg::ovf32(66'(x2_q) + 66'(y2_q)) | ldi_pkg::ovf32(66'(xy_q) <<< 1);
  assign f4 = ldi_pkg::ovf32(66'(r2_q) + (66'(x2b_q) <<< 1))
            | ldi_pkg::ovf32(66'(r2_q) + (66'(y2b_q) <<< 1));
  assign f5 = ldi_pkg::ovf32(66'(m4_q >>> 28) + 66'(coef_i.k2));
  assign f7 = ldi_pkg::ovf32(66'(m6_q >>> 28) + 66'(coef_i.k1))
            | ldi_pkg::ovf32(66'(it6_q.dx) - 66'(tx_q))
            | ldi_pkg::ovf32(66'(it6_q.dy) - 66'(ty_q));
  assign f9 = ldi_pkg::ovf32(66'(m8_q >>> 28) + 66'sd16777216);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[8:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      pxx_q  <= 64'(item_i.cx) * 64'(item_i.cx);
      pyy_q  <= 64'(item_i.cy) * 64'(item_i.cy);
      pxy_q  <= 64'(item_i.cx) * 64'(item_i.cy);

      it2_q  <= {it1_q.dx, it1_q.dy, it1_q.cx, it1_q.cy, it1_q.fault | f2};
      x2_q   <= ldi_pkg::sat32(66'(pxx_q >>> 28));
      y2_q   <= ldi_pkg::sat32(66'(pyy_q >>> 28));
      xy_q   <= ldi_pkg::sat32(66'(pxy_q >>> 28));

      it3_q  <= {it2_q.dx, it2_q.dy, it2_q.cx, it2_q.cy, it2_q.fault | f3};
      x2b_q  <= x2_q;
      y2b_q  <= y2_q;
      r2_q   <= ldi_pkg::sat32(66'(x2_q) + 66'(y2_q));
      xy2_q  <= ldi_pkg::sat32(66'(xy_q) <<< 1);

      it4_q  <= {it3_q.dx, it3_q.dy, it3_q.cx, it3_q.cy, it3_q.fault | f4};
      r2b_q  <= r2_q;
      xy2b_q <= xy2_q;
      sx_q   <= ldi_pkg::sat32(66'(r2_q) + (66'(x2b_q) <<< 1));
      sy_q   <= ldi_pkg::sat32(66'(r2_q) + (66'(y2b_q) <<< 1));
      m4_q   <= 64'(coef_i.k3) * 64'(r2_q);

      it5_q  <= {it4_q.dx, it4_q.dy, it4_q.cx, it4_q.cy, it4_q.fault | f5};
      r2c_q  <= r2b_q;
      acc1_q <= ldi_pkg::sat32(66'(m4_q >>> 28) + 66'(coef_i.k2));
      tp0_q  <= 64'(coef_i.p1) * 64'(xy2b_q);
      tp1_q  <= 64'(coef_i.p2) * 64'(sx_q);
      tp2_q  <= 64'(coef_i.p1) * 64'(sy_q);
      tp3_q  <= 64'(coef_i.p2) * 64'(xy2b_q);

      it6_q  <= it5_q;
      r2d_q  <= r2c_q;
      m6_q   <= 64'(acc1_q) * 64'(r2c_q);
      tx_q   <= 41'(tp0_q >>> 24) + 41'(tp1_q >>> 24);
      ty_q   <= 41'(tp2_q >>> 24) + 41'(tp3_q >>> 24);

      it7_q  <= {it6_q.dx, it6_q.dy, it6_q.cx, it6_q.cy, it6_q.fault | f7};
      r2e_q  <= r2d_q;
      acc2_q <= ldi_pkg::sat32(66'(m6_q >>> 28) + 66'(coef_i.k1));
      nx_q   <= ldi_pkg::sat32(66'(it6_q.dx) - 66'(tx_q));
      ny_q   <= ldi_pkg::sat32(66'(it6_q.dy) - 66'(ty_q));

      it8_q  <= it7_q;
      nx8_q  <= nx_q;
      ny8_q  <= ny_q;
      m8_q   <= 64'(acc2_q) * 64'(r2e_q);

      it9_q  <= {it8_q.dx, it8_q.dy, it8_q.cx, it8_q.cy, it8_q.fault | f9};
      nx9_q  <= nx8_q;
      ny9_q  <= ny8_q;
      g_q    <= ldi_pkg::sat32(66'(m8_q >>> 28) + 66'sd16777216);
    end
  end

  // divider prep
  logic [31:0] gabs, nxabs, nyabs;
  ldi_dv_t     dv_d [0:ldi_pkg::DIV_STAGES];
  ldi_dv_t     dv_q [0:ldi_pkg::DIV_STAGES];
  logic [ldi_pkg::DIV_STAGES:0] dv_v_q;

  assign gabs  = g_q[31] ? (~g_q + 32'd1) : g_q;
  assign nxabs = nx9_q[31] ? (~nx9_q + 32'd1) : nx9_q;
  assign nyabs = ny9_q[31] ? (~ny9_q + 32'd1) : ny9_q;

  always_comb begin
    dv_d[0].item     = it9_q;
    dv_d[0].gabs     = gabs;
    dv_d[0].gz       = (g_q == '0);
    dv_d[0].lx.rem   = {9'd0, nxabs[31:8]};
    dv_d[0].lx.low   = {nxabs[7:0], 24'd0};
    dv_d[0].lx.q     = '0;
    dv_d[0].lx.ovf   = {8'd0, nxabs[31:8]} >= gabs;
    dv_d[0].lx.rneg  = nx9_q[31] ^ g_q[31];
    dv_d[0].lx.nneg  = nx9_q[31];
    dv_d[0].lx.nzero = (nx9_q == '0);
    dv_d[0].ly.rem   = {9'd0, nyabs[31:8]};
    dv_d[0].ly.low   = {nyabs[7:0], 24'd0};
    dv_d[0].ly.q     = '0;
    dv_d[0].ly.ovf   = {8'd0, nyabs[31:8]} >= gabs;
    dv_d[0].ly.rneg  = ny9_q[31] ^ g_q[31];
    dv_d[0].ly.nneg  = ny9_q[31];
    dv_d[0].ly.nzero = (ny9_q == '0);
  end

  function automatic ldi_lane_t div_step(input ldi_lane_t l, input logic [31:0] d);
    ldi_lane_t r;
    logic [32:0] t;
    r = l;
    for (int unsigned i = 0; i < ldi_pkg::DIV_STEPS_PER_STAGE; i++) begin
      t = {r.rem[31:0], r.low[31]};
      r.low = {r.low[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = t - {1'b0, d};
        r.q   = {r.q[30:0], 1'b1};
      end else begin
        r.rem = t;
        r.q   = {r.q[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  for (genvar s = 1; s <= ldi_pkg::DIV_STAGES; s++) begin : g_div
    always_comb begin
      dv_d[s]    = dv_q[s-1];
      dv_d[s].lx = div_step(dv_q[s-1].lx, dv_q[s-1].gabs);
      dv_d[s].ly = div_step(dv_q[s-1].ly, dv_q[s-1].gabs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q <= '0;
    end else if (en_i) begin
      dv_v_q <= {dv_v_q[ldi_pkg::DIV_STAGES-1:0], v_q[9]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  // quotient sign and saturation
  function automatic logic [32:0] fin(input ldi_lane_t l, input logic gz);
    logic [32:0] r;
    if (gz) begin
      r = {1'b1, l.nzero ? 32'h0 : (l.nneg ? 32'h80000000 : 32'h7fffffff)};
    end else if (!l.rneg) begin
      if (l.ovf || l.q[31]) r = {1'b1, 32'h7fffffff};
      else r = {1'b0, l.q};
    end else begin
      if (l.ovf || (l.q > 32'h80000000)) r = {1'b1, 32'h80000000};
      else r = {1'b0, ~l.q + 32'd1};
    end
    return r;
  endfunction

  ldi_dv_t     dl;
  logic [32:0] rx, ry;
  logic        fv_q;
  ldi_pkg::ldi_item_t fi_q;

  assign dl = dv_q[ldi_pkg::DIV_STAGES];
  assign rx = fin(dl.lx, dl.gz);
  assign ry = fin(dl.ly, dl.gz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= dv_v_q[ldi_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fi_q <= {dl.item.dx, dl.item.dy, rx[31:0], ry[31:0],
               dl.item.fault | rx[32] | ry[32]};
    end
  end

  assign valid_o = fv_q;
  assign item_o  = fi_q;

endmodule

// File: hdl/lens_distortion_inverse.sv
// Iterative Brown-Conrady undistortion: each distorted Q3.28 coordinate pair runs
// through ten unrolled, fully pipelined iterations, each made of nine stages for the
// products, gain and tangential terms and ten stages for the division (an operand
// stage, eight radix-2 stages taking four quotient bits each and a sign/saturation
// stage), plus one output register. One word can be accepted every cycle unless the
// output is stalled; the whole pipeline holds while an output word waits under stall.
// The user must write coefficients through the configuration port only while the
// pipeline is empty; the block does not enforce this. cfg_ready_o is always high.
module lens_distortion_inverse (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [31:0]                   dist_x_i,
  input  logic signed [31:0]                   dist_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   undist_x_o,
  output logic signed [31:0]                   undist_y_o,
  output logic                                 math_fault_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ldi_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic signed [31:0]                   cfg_data_i
);

  ldi_pkg::ldi_coef_t coef_q;
  logic               en;
  logic               out_valid_q;
  ldi_pkg::ldi_item_t out_q;

  logic               v   [0:ldi_pkg::ITERATIONS];
  ldi_pkg::ldi_item_t itm [0:ldi_pkg::ITERATIONS];

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ldi_pkg::REG_RADIAL_K1:     coef_q.k1 <= cfg_data_i;
        ldi_pkg::REG_RADIAL_K2:     coef_q.k2 <= cfg_data_i;
        ldi_pkg::REG_RADIAL_K3:     coef_q.k3 <= cfg_data_i;
        ldi_pkg::REG_TANGENTIAL_P1: coef_q.p1 <= cfg_data_i;
        ldi_pkg::REG_TANGENTIAL_P2: coef_q.p2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign v[0]         = in_valid_i;
  assign itm[0].dx    = dist_x_i;
  assign itm[0].dy    = dist_y_i;
  assign itm[0].cx    = dist_x_i;
  assign itm[0].cy    = dist_y_i;
  assign itm[0].fault = 1'b0;

  for (genvar i = 0; i < ldi_pkg::ITERATIONS; i++) begin : g_iter
    ldi_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .coef_i  (coef_q),
      .valid_i (v[i]),
      .item_i  (itm[i]),
      .valid_o (v[i+1]),
      .item_o  (itm[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[ldi_pkg::ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= itm[ldi_pkg::ITERATIONS];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign undist_x_o   = out_q.cx;
  assign undist_y_o   = out_q.cy;
  assign math_fault_o = out_q.fault;

endmodule

// File: hdl/ldi_checker.sv
module ldi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] undist_x_o,
  input logic        cfg_ready_o
);

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output word");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(undist_x_o)))
    else $error("stalled output word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind lens_distortion_inverse ldi_checker u_ldi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .undist_x_o  (undist_x_o),
  .cfg_ready_o (cfg_ready_o)
);

// File: sim/lens_distortion_inverse_tb.sv
module lens_distortion_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_REGS = 5;
  localparam int unsigned LATENCY = 191;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint Q24_ONE = 64'sd1 << 24;
  localparam longint Q28_ONE = 64'sd1 << 28;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               fault;
  } undist_word_t;

  class undistort_scoreboard;
    longint         coef [NUM_REGS];
    undist_word_t   pending [$];
    int             errors;
    bit             flt;

    function new();
      foreach (coef[i]) coef[i] = 0;
      errors = 0;
    endfunction

    function longint clamp(longint v);
      if (v > S32_HI) begin
        flt = 1;
        return S32_HI;
      end
      if (v < S32_LO) begin
        flt = 1;
        return S32_LO;
      end
      return v;
    endfunction

    function void set_coef(logic [ldi_pkg::CFG_INDEX_W-1:0] idx, logic signed [31:0] val);
      if (idx < NUM_REGS) coef[idx] = longint'(val);
    endfunction

    function void note_input(logic signed [31:0] dx_w, logic signed [31:0] dy_w);
      longint dx, dy, cx, cy, x2, y2, xy, r2, acc, g, xy2, sx, sy, tx, ty, nx, ny;
      longint k1, k2, k3, p1, p2;
      undist_word_t w;
      k1 = coef[ldi_pkg::REG_RADIAL_K1];
      k2 = coef[ldi_pkg::REG_RADIAL_K2];
      k3 = coef[ldi_pkg::REG_RADIAL_K3];
      p1 = coef[ldi_pkg::REG_TANGENTIAL_P1];
      p2 = coef[ldi_pkg::REG_TANGENTIAL_P2];
      dx = longint'(dx_w);
      dy = longint'(dy_w);
      cx = dx;
      cy = dy;
      flt = 0;
      for (int it = 0; it < ldi_pkg::ITERATIONS; it++) begin
        x2 = clamp((cx * cx) >>> 28);
        y2 = clamp((cy * cy) >>> 28);
        xy = clamp((cx * cy) >>> 28);
        r2 = clamp(x2 + y2);
        acc = k3;
        acc = clamp(((acc * r2) >>> 28) + k2);
        acc = clamp(((acc * r2) >>> 28) + k1);
        g = clamp(((acc * r2) >>> 28) + Q24_ONE);
        xy2 = clamp(2 * xy);
        sx = clamp(r2 + 2 * x2);
        sy = clamp(r2 + 2 * y2);
        tx = ((p1 * xy2) >>> 24) + ((p2 * sx) >>> 24);
        ty = ((p1 * sy) >>> 24) + ((p2 * xy2) >>> 24);
        nx = clamp(dx - tx);
        ny = clamp(dy - ty);
        if (g == 0) begin
          flt = 1;
          cx = nx > 0 ? S32_HI : (nx < 0 ? S32_LO : 0);
          cy = ny > 0 ? S32_HI : (ny < 0 ? S32_LO : 0);
        end else begin
          cx = clamp((nx * Q24_ONE) / g);
          cy = clamp((ny * Q24_ONE) / g);
        end
      end
      w.x = cx[31:0];
      w.y = cy[31:0];
      w.fault = flt;
      pending = {pending, w};
    endfunction

    function void check_result(logic signed [31:0] ux, logic signed [31:0] uy, logic f);
      undist_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h fault=%b", $time, ux, uy, f);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (ux !== w.x) begin
        $display("%0t: undist_x expected %h actual %h", $time, w.x, ux);
        errors++;
      end
      if (uy !== w.y) begin
        $display("%0t: undist_y expected %h actual %h", $time, w.y, uy);
        errors++;
      end
      if (f !== w.fault) begin
        $display("%0t: math_fault expected %b actual %b", $time, w.fault, f);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic signed [31:0]              dist_x_i;
  logic signed [31:0]              dist_y_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic signed [31:0]              undist_x_o;
  logic signed [31:0]              undist_y_o;
  logic                            math_fault_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [ldi_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic signed [31:0]              cfg_data_i;

  undistort_scoreboard sb;
  bit tx_quiet;
  bit rx_quiet;
  bit hold_req;

  lens_distortion_inverse dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dist_x_i    (dist_x_i),
    .dist_y_i    (dist_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .undist_x_o  (undist_x_o),
    .undist_y_o  (undist_y_o),
    .math_fault_o(math_fault_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #3ms;
    $display("lens_distortion_inverse: mismatch");
    $finish;
  end

  // receiver: random stall before each word, plus one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
      end
      n = rx_quiet ? 0 : $urandom_range(0, 19);
      out_stall_i = (n > 0);
      if (n > 0) begin
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(undist_x_o, undist_y_o, math_fault_o);
    end
  end

  task automatic send_word(logic signed [31:0] dx, logic signed [31:0] dy);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    dist_x_i = dx;
    dist_y_i = dy;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(dx, dy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ldi_pkg::CFG_INDEX_W-1:0] idx, logic signed [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_coef(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(logic signed [31:0] k1, logic signed [31:0] k2,
                           logic signed [31:0] k3, logic signed [31:0] p1,
                           logic signed [31:0] p2);
    write_reg(ldi_pkg::REG_RADIAL_K1, k1);
    write_reg(ldi_pkg::REG_RADIAL_K2, k2);
    write_reg(ldi_pkg::REG_RADIAL_K3, k3);
    write_reg(ldi_pkg::REG_TANGENTIAL_P1, p1);
    write_reg(ldi_pkg::REG_TANGENTIAL_P2, p2);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 32'h60000000)) - 32'sh30000000;
  endfunction

  function automatic logic signed [31:0] rand_coef(int unsigned span);
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  task automatic directed_set();
    send_word(32'sd0, 32'sd0);
    send_word(32'sh7fffffff, 32'sh7fffffff);
    send_word(32'sh80000000, 32'sh80000000);
    send_word(32'sh7fffffff, 32'sh80000000);
    send_word(32'(Q28_ONE), 32'sd0);
    send_word(-32'(Q28_ONE), 32'(Q28_ONE / 2));
  endtask

  task automatic random_words(int cnt);
    for (int i = 0; i < cnt; i++) send_word(rand_coord(), rand_coord());
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    dist_x_i = '0;
    dist_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    tx_quiet = 0;
    rx_quiet = 0;
    hold_req = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients
    directed_set();
    drain();
    // typical lens
    write_all(-32'sd5033165, 32'sd1677721, -32'sd167772, 32'sd16777, -32'sd33554);
    directed_set();
    drain();
    // zero gain on the first pass
    write_all(-32'(Q24_ONE), 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(32'(Q28_ONE), 32'sd0);
    send_word(-32'(Q28_ONE), 32'sd0);
    send_word(32'sd0, 32'(Q28_ONE));
    drain();
    write_all(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    directed_set();
    drain();
    write_all(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    directed_set();
    drain();
    // indexes past the last register must leave the coefficients alone
    for (int idx = NUM_REGS; idx < (1 << ldi_pkg::CFG_INDEX_W); idx++) begin
      write_reg(ldi_pkg::CFG_INDEX_W'(idx), $urandom);
    end
    send_word(32'(Q28_ONE / 2), -32'(Q28_ONE / 3));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_all(rand_coef(32'h00800000), rand_coef(32'h00400000), rand_coef(32'h00200000),
                rand_coef(32'h00080000), rand_coef(32'h00080000));
      tx_quiet = (ph % 3 == 1);
      rx_quiet = (ph % 4 == 2);
      if (ph == 3) begin
        tx_quiet = 1;
        hold_req = 1;
        random_words(300);
      end else begin
        random_words(220);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("lens_distortion_inverse: match");
    end else begin
      $display("lens_distortion_inverse: mismatch");
    end
    $finish;
  end

endmodule
